// ----- hw/rtl/i2c3w_pkg.sv -----
`default_nettype none
package i2c3w_pkg;

	// Queue between the tick front end and the bus sequencer
	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	// Control byte values and register reset values
	localparam logic [7:0] CTRL_CMD   = 8'h00;
	localparam logic [7:0] CTRL_DATA  = 8'h40;
	localparam logic [7:0] ADDR_RESET = 8'h78;
	localparam logic [7:0] HP_RESET   = 8'h01;

	// Configuration register indexes
	localparam logic CFG_DEVICE_ADDRESS = 1'b0;
	localparam logic CFG_HALF_PERIOD    = 1'b1;

	// One classified tick as it travels through the queue
	typedef struct packed {
		logic       req;
		logic       mode;
		logic [7:0] payload;
		logic       sda_low;
	} tick_t;

	// Queue status seen by the front end and the sequencer
	typedef struct packed {
		logic full;
		logic valid;
	} q_stat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/i2c3w_front.sv -----
`default_nettype none
module i2c3w_front
	import i2c3w_pkg::*;
(
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // is_data, payload[7:0], sda_in, zero fill
	input  wire logic        s_tuser,  // func
	input  wire q_stat_t     q_stat,
	output logic             push,
	output tick_t            item
);

	// Take a tick whenever the queue has room
	assign s_tready = !q_stat.full;
	assign push     = s_tvalid && s_tready;

	// Unpack the transfer and classify it as plain tick or write request
	always_comb begin
		item.req     = s_tuser;
		item.mode    = s_tdata[0];
		item.payload = s_tdata[8:1];
		item.sda_low = !s_tdata[9];
	end

endmodule
`default_nettype wire

// ----- hw/rtl/i2c3w_queue.sv -----
`default_nettype none
module i2c3w_queue
	import i2c3w_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire tick_t push_item,
	input  wire logic  pop,
	output tick_t      head,
	output q_stat_t    q_stat
);

	tick_t            mem_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QAW:0]     cnt_q;

	assign q_stat.full  = (cnt_q == QDEPTH[QAW:0]);
	assign q_stat.valid = (cnt_q != '0);
	assign head         = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/i2c3w_back.sv -----
`default_nettype none
module i2c3w_back
	import i2c3w_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire q_stat_t    q_stat,
	input  wire tick_t      head,
	output logic            pop,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata
);

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_START_HI  = 4'd1,
		PH_START_LO  = 4'd2,
		PH_BIT_LOW   = 4'd3,
		PH_BIT_HIGH  = 4'd4,
		PH_RELEASE   = 4'd5,
		PH_ACK_HIGH  = 4'd6,
		PH_ACK_LOW   = 4'd7,
		PH_STOP_LOW  = 4'd8,
		PH_STOP_HIGH = 4'd9
	} phase_t;

	logic [7:0] dev_addr_q;
	logic [7:0] half_period_q;

	phase_t     phase_q, phase_n, ph_go;
	logic [7:0] shift_q, shift_n;
	logic [2:0] bit_q, bit_n;
	logic [1:0] byte_q, byte_n;
	logic [7:0] hold_q, hold_n;
	logic [7:0] pay_q, pay_n;
	logic       mode_q, mode_n;
	logic [1:0] lv_q, lv_n;   // bit 1 SCL, bit 0 SDA
	logic       go, rej, done, busy;
	logic       m_tvalid_q;
	logic [7:0] m_tdata_q;

	// Run one tick when the head is there and the output register can take it
	assign pop      = q_stat.valid && (!m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Next state of the bus sequencer for the tick at the queue head
	always_comb begin
		phase_n = phase_q;
		shift_n = shift_q;
		bit_n   = bit_q;
		byte_n  = byte_q;
		hold_n  = hold_q;
		pay_n   = pay_q;
		mode_n  = mode_q;
		lv_n    = lv_q;
		rej     = 1'b0;
		done    = 1'b0;
		go      = 1'b0;
		ph_go   = PH_IDLE;

		if (phase_q == PH_IDLE) begin
			lv_n = 2'b11;
			if (head.req) begin
				pay_n   = head.payload;
				mode_n  = head.mode;
				byte_n  = 2'd0;
				bit_n   = 3'd0;
				shift_n = dev_addr_q;
				go      = 1'b1;
				ph_go   = PH_START_HI;
			end
		end else begin
			rej = head.req;
			if (phase_q == PH_ACK_HIGH) begin
				// Hold SCL high until the slave pulls SDA low
				if (hold_q >= half_period_q) begin
					if (head.sda_low) begin
						go    = 1'b1;
						ph_go = PH_ACK_LOW;
					end
				end else begin
					hold_n = hold_q + 8'd1;
				end
			end else if (hold_q < half_period_q) begin
				hold_n = hold_q + 8'd1;
			end else begin
				case (phase_q)
					PH_START_HI: begin
						go    = 1'b1;
						ph_go = PH_START_LO;
					end
					PH_START_LO: begin
						go    = 1'b1;
						ph_go = PH_BIT_LOW;
					end
					PH_BIT_LOW: begin
						go    = 1'b1;
						ph_go = PH_BIT_HIGH;
					end
					PH_BIT_HIGH: begin
						go = 1'b1;
						if (bit_q == 3'd7) begin
							ph_go = PH_RELEASE;
						end else begin
							bit_n   = bit_q + 3'd1;
							shift_n = {shift_q[6:0], 1'b0};
							ph_go   = PH_BIT_LOW;
						end
					end
					PH_RELEASE: begin
						go    = 1'b1;
						ph_go = PH_ACK_HIGH;
					end
					PH_ACK_LOW: begin
						go = 1'b1;
						if (byte_q >= 2'd2) begin
							ph_go = PH_STOP_LOW;
						end else begin
							byte_n  = byte_q + 2'd1;
							shift_n = (byte_q == 2'd0) ?
								(mode_q ? CTRL_DATA : CTRL_CMD) : pay_q;
							bit_n   = 3'd0;
							ph_go   = PH_BIT_LOW;
						end
					end
					PH_STOP_LOW: begin
						go    = 1'b1;
						ph_go = PH_STOP_HIGH;
					end
					default: begin
						// Stop condition complete, back to idle
						phase_n = PH_IDLE;
						hold_n  = 8'd0;
						lv_n    = 2'b11;
						done    = 1'b1;
					end
				endcase
			end
		end

		// Enter the new line state; bit states drive the current MSB
		if (go) begin
			phase_n = ph_go;
			hold_n  = 8'd1;
			case (ph_go)
				PH_START_HI:  lv_n = 2'b11;
				PH_START_LO:  lv_n = 2'b10;
				PH_BIT_LOW:   lv_n = {1'b0, shift_n[7]};
				PH_BIT_HIGH:  lv_n = {1'b1, shift_n[7]};
				PH_RELEASE:   lv_n = 2'b01;
				PH_ACK_HIGH:  lv_n = 2'b11;
				PH_ACK_LOW:   lv_n = 2'b01;
				PH_STOP_LOW:  lv_n = 2'b00;
				PH_STOP_HIGH: lv_n = 2'b10;
				default:      lv_n = 2'b11;
			endcase
		end

		busy = (phase_n != PH_IDLE);
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q    <= ADDR_RESET;
			half_period_q <= HP_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_DEVICE_ADDRESS) begin
				dev_addr_q <= cfg_data;
			end else begin
				half_period_q <= cfg_data;
			end
		end
	end

	// Sequencer state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			shift_q    <= '0;
			bit_q      <= '0;
			byte_q     <= '0;
			hold_q     <= '0;
			pay_q      <= '0;
			mode_q     <= 1'b0;
			lv_q       <= 2'b11;
			m_tvalid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q    <= phase_n;
				shift_q    <= shift_n;
				bit_q      <= bit_n;
				byte_q     <= byte_n;
				hold_q     <= hold_n;
				pay_q      <= pay_n;
				mode_q     <= mode_n;
				lv_q       <= lv_n;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			m_tdata_q <= {3'b000, rej, done, busy, lv_n[0], lv_n[1]};
		end
	end

	// Done only ends a stop condition
	a_done_from_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && done) |-> (phase_q == PH_STOP_HIGH))
		else $error("done outside stop high");

	// Rejection only while a transaction runs
	a_rej_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && rej) |-> (phase_q != PH_IDLE))
		else $error("reject while idle");

	// Hold counter is live in every active phase
	a_hold_live: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE) |-> (hold_q != 8'd0))
		else $error("hold counter zero while busy");

	// A request in idle starts a transaction on the next cycle
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.req && (phase_q == PH_IDLE)) |=> (phase_q == PH_START_HI))
		else $error("request did not start");

endmodule
`default_nettype wire

// ----- hw/rtl/i2c_three_byte_write_master_unit.sv -----
// Accepted ticks enter the tick queue; each result is registered at the output.
// Throughput: one tick per clock cycle, sustained while the result side takes a
// transfer every cycle; a four-entry tick queue absorbs output stalls.
// Each tick is one pass of the bus sequencer, one register update per cycle unless stalled.
// Reset (arst_n low, asynchronous): sequencer idle with both lines high, queue empty,
// device_address 0x78, half_period 1.
`default_nettype none
module i2c_three_byte_write_master_unit
	import i2c3w_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // is_data, payload[7:0], sda_in, zero fill
	input  wire logic        s_tuser,  // func
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata   // scl, sda_out, busy_res, done_res, rejected, fill
);

	q_stat_t q_stat;
	tick_t   push_item;
	tick_t   head;
	logic    push;
	logic    pop;

	// Configuration is always taken
	assign cfg_ready = 1'b1;

	i2c3w_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_stat   (q_stat),
		.push     (push),
		.item     (push_item)
	);

	i2c3w_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	i2c3w_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_stat    (q_stat),
		.head      (head),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
`default_nettype wire
